/* rtl/seven_segment_to_text_core_macros.svh */
// Assertion macros shared by the RTL of the seven-segment to text core.
`ifndef SEVEN_SEGMENT_TO_TEXT_CORE_MACROS_SVH
`define SEVEN_SEGMENT_TO_TEXT_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define SSTT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SSTT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sstt_pkg.sv */
// Types, constants and lookup functions of the seven-segment to text core.
package sstt_pkg;

   localparam int DIGIT_COUNT = 11;

   localparam logic [3:0] ANN_FIRST_POS = 4'd2;
   localparam logic [3:0] ANN_LAST_POS  = 4'd10;
   localparam logic [3:0] POS_MAX       = 4'd15;

   localparam int SLOT_COUNT = 14;
   localparam int FLAG_COUNT = 9;

   typedef logic [3:0]            slot_idx_type;
   typedef logic [SLOT_COUNT-1:0] slot_mask_type;
   typedef logic [FLAG_COUNT-1:0] flag_vec_type;
   typedef logic [7:0]            char_type;

   // Fixed places of the result characters of one item, in emission order.
   localparam slot_idx_type SLOT_GLYPH  = 4'd0;
   localparam slot_idx_type SLOT_MARK   = 4'd1;
   localparam slot_idx_type SLOT_SEP    = 4'd2;
   localparam slot_idx_type SLOT_LOWBAT = 4'd3;
   localparam slot_idx_type SLOT_FLAG0  = 4'd4;
   localparam slot_idx_type SLOT_TERM   = 4'd13;

   localparam char_type CHAR_SEP    = 8'h5F;
   localparam char_type CHAR_LOWBAT = 8'h4C;
   localparam char_type CHAR_COMMA  = 8'h2C;
   localparam char_type CHAR_POINT  = 8'h2E;
   localparam char_type CHAR_TERM   = 8'h00;

   typedef struct packed {
      logic     hit;
      char_type ch;
   } glyph_type;

   function automatic glyph_type seg_to_glyph(input logic [6:0] seg);
      glyph_type g;
      g.hit = 1'b1;
      unique case (seg)
         7'h40:   g.ch = 8'h2D;
         7'h3F:   g.ch = 8'h30;
         7'h06:   g.ch = 8'h31;
         7'h5B:   g.ch = 8'h32;
         7'h4F:   g.ch = 8'h33;
         7'h66:   g.ch = 8'h34;
         7'h6D:   g.ch = 8'h35;
         7'h7D:   g.ch = 8'h36;
         7'h07:   g.ch = 8'h37;
         7'h7F:   g.ch = 8'h38;
         7'h6F:   g.ch = 8'h39;
         7'h73:   g.ch = 8'h50;
         7'h79:   g.ch = 8'h45;
         7'h02:   g.ch = 8'h69;
         7'h23:   g.ch = 8'h6E;
         7'h5C:   g.ch = 8'h4F;
         7'h50:   g.ch = 8'h52;
         7'h21:   g.ch = 8'h72;
         7'h62:   g.ch = 8'h75;
         7'h7C:   g.ch = 8'h62;
         7'h5E:   g.ch = 8'h64;
         7'h74:   g.ch = 8'h68;
         7'h77:   g.ch = 8'h41;
         7'h39:   g.ch = 8'h43;
         7'h71:   g.ch = 8'h46;
         7'h00:   g.ch = 8'h20;
         default: begin
            g.hit = 1'b0;
            g.ch  = CHAR_TERM;
         end
      endcase
      return g;
   endfunction

   // Annunciator letters U f g B G R D C P, by flag index.
   function automatic char_type flag_letter(input slot_idx_type idx);
      char_type ch;
      unique case (idx)
         4'd0:    ch = 8'h55;
         4'd1:    ch = 8'h66;
         4'd2:    ch = 8'h67;
         4'd3:    ch = 8'h42;
         4'd4:    ch = 8'h47;
         4'd5:    ch = 8'h52;
         4'd6:    ch = 8'h44;
         4'd7:    ch = 8'h43;
         4'd8:    ch = 8'h50;
         default: ch = CHAR_TERM;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/sstt_req_if.sv */
// Input channel of the seven-segment to text core: one display digit word per item.
interface sstt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] segments;
   logic        final_digit;

   modport source (output valid, segments, final_digit, input ready);
   modport sink   (input valid, segments, final_digit, output ready);
endinterface

/* rtl/sstt_rsp_if.sv */
// Result channel of the seven-segment to text core: one text character per item.
interface sstt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_text;

   modport source (output valid, character, end_of_text, input ready);
   modport sink   (input valid, character, end_of_text, output ready);
endinterface

/* rtl/seven_segment_to_text_core.sv */
// Top level of the seven-segment to text core: digit words in, text characters out.
//
//   channel  direction  payload                        handshake
//   req_if   in         segments[15:0], final_digit    valid / ready
//   rsp_if   out        character[7:0], end_of_text    valid / ready
//   csr      in         csr_wdata (low battery)        csr_we, no wait
//
// An input item is decoded in the cycle it is accepted into a pending slot register that
// holds every character it causes: up to two for a digit, up to fourteen at the end of a
// frame. One character leaves per cycle while rsp_if is ready, so an item stays pending
// until every result it causes is taken; the single result port sets this pace.
// The next item is accepted in the same cycle that the last pending character is taken.
// Reset is synchronous and clears the slots, the digit position, the flags and low battery.
// A stall on rsp_if holds the pending character and back-pressures req_if.
`include "seven_segment_to_text_core_macros.svh"

module seven_segment_to_text_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   sstt_req_if.sink   req_if,
   sstt_rsp_if.source rsp_if
);
   import sstt_pkg::*;

   // Control state.
   slot_mask_type mask_ff, mask_in;
   logic [3:0]    pos_ff, pos_in;
   flag_vec_type  flags_ff, flags_in;
   logic          low_battery_ff;

   // Payload of the two digit slots; the other slots hold fixed characters.
   char_type      glyph_ff, glyph_in;
   char_type      mark_ff, mark_in;

   logic          req_take;
   logic          rsp_take;
   slot_idx_type  head_idx;
   slot_mask_type mask_rest;
   slot_mask_type mask_new;
   glyph_type     glyph;
   logic          ann_hit;
   flag_vec_type  flags_next;

   // The lowest pending slot is the next character out.
   always_comb begin
      head_idx = SLOT_TERM;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            head_idx = slot_idx_type'(i);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - slot_mask_type'(1));

   assign rsp_if.valid       = |mask_ff;
   assign rsp_if.end_of_text = (head_idx == SLOT_TERM);
   assign rsp_take           = rsp_if.valid && rsp_if.ready;

   always_comb begin
      case (head_idx)
         SLOT_GLYPH:  rsp_if.character = glyph_ff;
         SLOT_MARK:   rsp_if.character = mark_ff;
         SLOT_SEP:    rsp_if.character = CHAR_SEP;
         SLOT_LOWBAT: rsp_if.character = CHAR_LOWBAT;
         SLOT_TERM:   rsp_if.character = CHAR_TERM;
         default:     rsp_if.character = flag_letter(head_idx - SLOT_FLAG0);
      endcase
   end

   // Ready when nothing is pending, or when the last pending character goes out now.
   assign req_if.ready = (mask_ff == '0) || (rsp_take && (mask_rest == '0));
   assign req_take     = req_if.valid && req_if.ready;

   // Decode of the incoming digit word.
   always_comb begin
      glyph = seg_to_glyph(req_if.segments[6:0]);

      // Annunciator bits count only at positions 2 through 10 of the display.
      ann_hit = (|req_if.segments[15:9]) && (pos_ff >= ANN_FIRST_POS) &&
                (pos_ff <= ANN_LAST_POS) && (int'(pos_ff) < DIGIT_COUNT);
      flags_next = flags_ff;
      if (ann_hit) begin
         flags_next = flags_ff | (flag_vec_type'(1) << (pos_ff - ANN_FIRST_POS));
      end

      mask_new              = '0;
      mask_new[SLOT_GLYPH]  = glyph.hit;
      mask_new[SLOT_MARK]   = req_if.segments[8] || req_if.segments[7];
      glyph_in              = glyph.ch;
      // The comma wins over the point when both are lit.
      mark_in               = req_if.segments[8] ? CHAR_COMMA : CHAR_POINT;

      if (req_if.final_digit) begin
         mask_new[SLOT_SEP]    = 1'b1;
         mask_new[SLOT_LOWBAT] = low_battery_ff;
         mask_new[SLOT_TERM-1:SLOT_FLAG0] = flags_next;
         mask_new[SLOT_TERM]   = 1'b1;
         pos_in   = '0;
         flags_in = '0;
      end else begin
         pos_in   = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 4'd1;
         flags_in = flags_next;
      end

      if (req_take) begin
         mask_in = mask_new;
      end else if (rsp_take) begin
         mask_in = mask_rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= '0;
         pos_ff         <= '0;
         flags_ff       <= '0;
         low_battery_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (req_take) begin
            pos_ff   <= pos_in;
            flags_ff <= flags_in;
         end
         if (csr_we) begin
            low_battery_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         glyph_ff <= glyph_in;
         mark_ff  <= mark_in;
      end
   end

   // A new item is never taken while more than one character of the last is pending.
   `SSTT_ASSERT(a_no_overrun, clock, reset, ($countones(mask_ff) > 1) |-> !req_if.ready, "item accepted over pending results")

   // The end of a frame restarts the position and clears the collected flags.
   `SSTT_ASSERT(a_frame_restart, clock, reset, (req_take && req_if.final_digit) |=> ((pos_ff == 4'd0) && (flags_ff == '0)), "frame end did not restart position and flags")

   // The terminator always carries the zero character.
   `SSTT_ASSERT(a_term_zero, clock, reset, (rsp_if.valid && rsp_if.end_of_text) |-> (rsp_if.character == CHAR_TERM), "terminator with nonzero character")

   // Without an accepted item no new pending slot appears.
   `SSTT_ASSERT(a_no_new_slots, clock, reset, !req_take |=> ((mask_ff & ~$past(mask_ff)) == '0), "pending slot appeared without an item")

   // Reset leaves nothing pending.
   `SSTT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (mask_ff == '0), "results pending after reset")

endmodule
